>>> src/multi_axis_cosine_motion_profiler_assert.svh
// Assertion macros for the motion profiler checker.
// Included by the checker file only; needs no package.
`ifndef MULTI_AXIS_COSINE_MOTION_PROFILER_ASSERT_SVH
`define MULTI_AXIS_COSINE_MOTION_PROFILER_ASSERT_SVH

// same-cycle implication under reset
`define MCP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under reset
`define MCP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mcp_pkg.sv
// Shared types and constants of the cosine motion profiler.
// No dependencies.
package mcp_pkg;

  localparam int CH_W          = 5;
  localparam int TGT_W         = 16;
  localparam int ANG_W         = 15;
  localparam int PH_W          = 17;
  localparam int POS_W         = 10;
  localparam int IN_TDATA_W    = 24;
  localparam int OUT_TDATA_W   = 32;
  localparam int NUM_CHANNELS_DEF       = 18;
  localparam int WEIGHT_TABLE_DEPTH_DEF = 256;

  localparam logic [PH_W-1:0]  PHASE_ONE    = 17'd65536;
  localparam logic [PH_W-1:0]  PHASE_STEP_RST = 17'd2621;
  localparam logic [ANG_W-1:0] ANGLE_MAX    = 15'd24000;
  localparam logic [7:0]       MOVE_TIME    = 8'd100;
  localparam logic [7:0]       FRAME_LEN    = 8'd7;
  localparam logic [7:0]       FRAME_CMD    = 8'd1;
  localparam logic [63:0]      PI_Q30       = 64'd3373259426;
  localparam logic [63:0]      ONE_Q30      = 64'd1 << 30;
  // 2^20 / 24 rounded up; exact floor for values below 2^17
  localparam logic [15:0]      DIV24_RECIP  = 16'd43691;

  localparam logic CMD_SET  = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  typedef struct packed {
    logic             tick;
    logic [CH_W-1:0]  ch;
    logic [ANG_W-1:0] target;
  } cmd_t;

  function automatic logic [7:0] frame_checksum(input logic [CH_W-1:0] id,
                                                input logic [POS_W-1:0] pos);
    logic [7:0] sum;
    sum = 8'(id) + FRAME_LEN + FRAME_CMD + pos[7:0] + 8'(pos[POS_W-1:8]) + MOVE_TIME;
    return ~sum;
  endfunction

endpackage

>>> src/mcp_front.sv
// Front end: accepts input words, clamps targets and drops set-target words for bad channels.
// Depends on mcp_pkg; feeds mcp_queue.
module mcp_front import mcp_pkg::*; #(
  parameter int NUM_CHANNELS = NUM_CHANNELS_DEF
) (
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [0:0]            in_tuser,
  output logic                  push,
  output cmd_t                  push_cmd,
  input  logic                  q_full
);

  logic                    accept;
  logic [CH_W-1:0]         ch;
  logic signed [TGT_W-1:0] tgt;
  logic [ANG_W-1:0]        clamped;
  logic                    ch_ok;

  assign in_tready = !q_full && rst_n;
  assign accept    = in_tvalid && in_tready;
  assign ch        = in_tdata[CH_W-1:0];
  assign tgt       = $signed(in_tdata[CH_W+TGT_W-1:CH_W]);
  assign ch_ok     = 32'(ch) < NUM_CHANNELS;

  always_comb begin
    if (tgt < 0) begin
      clamped = '0;
    end else if (tgt > $signed({1'b0, ANGLE_MAX})) begin
      clamped = ANGLE_MAX;
    end else begin
      clamped = ANG_W'(tgt);
    end
  end

  // drop set-target words for channels that do not exist
  assign push            = accept && (in_tuser[0] == CMD_TICK || ch_ok);
  assign push_cmd.tick   = in_tuser[0];
  assign push_cmd.ch     = ch;
  assign push_cmd.target = clamped;

endmodule

>>> src/mcp_queue.sv
// Two-entry command queue between front and back end.
// Depends on mcp_pkg.
module mcp_queue import mcp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output cmd_t head
);

  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = cnt_r == 2'd2;
  assign q_valid = cnt_r != 2'd0;
  assign head    = mem_r[rp_r];

  always_comb begin
    wp_nxt  = push ? !wp_r : wp_r;
    rp_nxt  = pop ? !rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

endmodule

>>> src/mcp_back.sv
// Back end: applies targets and walks channels on a tick.
// Depends on mcp_pkg; holds channel state, weight table and output register.
module mcp_back import mcp_pkg::*; #(
  parameter int NUM_CHANNELS       = NUM_CHANNELS_DEF,
  parameter int WEIGHT_TABLE_DEPTH = WEIGHT_TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [PH_W-1:0]        phase_step,
  input  logic                   q_valid,
  input  cmd_t                   head,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast
);

  localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
  localparam int TI_W  = $clog2(WEIGHT_TABLE_DEPTH + 1);
  localparam int P_W   = PH_W + TI_W;

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_W1   = 7'b0000100,
    ST_W2   = 7'b0001000,
    ST_ANG  = 7'b0010000,
    ST_POS  = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  function automatic logic [16:0] half_weight(input int j);
    logic [63:0] phi, t, s;
    phi = (PI_Q30 * 64'(j)) / WEIGHT_TABLE_DEPTH;
    t   = (phi * phi) >> 30;
    s   = ONE_Q30 - t / 182;
    s   = ONE_Q30 - ((t * s) >> 30) / 132;
    s   = ONE_Q30 - ((t * s) >> 30) / 90;
    s   = ONE_Q30 - ((t * s) >> 30) / 56;
    s   = ONE_Q30 - ((t * s) >> 30) / 30;
    s   = ONE_Q30 - ((t * s) >> 30) / 12;
    return 17'((((((t * s) >> 30) / 2) / 2) + 64'd8192) >> 14);
  endfunction

  function automatic logic [16:0] weight_entry(input int i);
    if (2 * i <= WEIGHT_TABLE_DEPTH) begin
      return half_weight(i);
    end
    return PHASE_ONE - half_weight(WEIGHT_TABLE_DEPTH - i);
  endfunction

  logic [16:0] wtab [WEIGHT_TABLE_DEPTH+1];
  for (genvar gi = 0; gi <= WEIGHT_TABLE_DEPTH; gi++) begin : g_tab
    assign wtab[gi] = weight_entry(gi);
  end

  state_t            state_r, state_nxt;
  logic [ANG_W-1:0]  cur_r   [NUM_CHANNELS];
  logic [ANG_W-1:0]  start_r [NUM_CHANNELS];
  logic [ANG_W-1:0]  tgt_r   [NUM_CHANNELS];
  logic [PH_W-1:0]   phase_r [NUM_CHANNELS];
  logic              moving_r [NUM_CHANNELS];

  logic [CNT_W-1:0]  ch_r;
  logic [IDX_W-1:0]  ci;
  logic [PH_W-1:0]   ph_r;
  logic [TI_W-1:0]   idx_r;
  logic [15:0]       frac_r;
  logic              full_r, last_r;
  logic [33:0]       acc_r;
  logic [PH_W-1:0]   w_r;
  logic [ANG_W-1:0]  angle_r;
  logic [POS_W-1:0]  pos_r;

  logic [PH_W:0]     ph_sum;
  logic [PH_W-1:0]   ph_sat;
  logic [P_W-1:0]    p_full;
  logic              later;
  logic [33:0]       prod_b;
  logic signed [ANG_W+1:0] d;
  logic [ANG_W-1:0]  d_mag;
  logic [31:0]       mag;
  logic [31:0]       pos_prod;
  logic [CH_W-1:0]   sid;
  logic              slot_free;
  logic [IDX_W-1:0]  set_i;

  assign ci        = ch_r[IDX_W-1:0];
  assign set_i     = IDX_W'(head.ch);
  assign slot_free = !out_tvalid || out_tready;
  assign sid       = CH_W'(ch_r) + CH_W'(1);

  assign ph_sum = {1'b0, phase_r[ci]} + {1'b0, phase_step};
  assign ph_sat = (ph_sum > {1'b0, PHASE_ONE}) ? PHASE_ONE : ph_sum[PH_W-1:0];
  assign p_full = P_W'(ph_sat) * P_W'(WEIGHT_TABLE_DEPTH);

  always_comb begin
    later = 1'b0;
    for (int k = 0; k < NUM_CHANNELS; k++) begin
      if (CNT_W'(k) > ch_r && moving_r[k]) begin
        later = 1'b1;
      end
    end
  end

  assign prod_b   = 34'(wtab[idx_r + TI_W'(1)]) * 34'(frac_r);
  assign d        = $signed({2'b00, tgt_r[ci]}) - $signed({2'b00, start_r[ci]});
  assign d_mag    = (d < 0) ? ANG_W'(-d) : ANG_W'(d);
  assign mag      = (32'(d_mag) * 32'(w_r)) >> 16;
  assign pos_prod = 32'(angle_r) * 32'(DIV24_RECIP);

  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          pop       = 1'b1;
          state_nxt = head.tick ? ST_SCAN : ST_IDLE;
        end
      end
      ST_SCAN: begin
        if (ch_r == CNT_W'(NUM_CHANNELS)) begin
          state_nxt = ST_IDLE;
        end else if (moving_r[ci]) begin
          state_nxt = ST_W1;
        end
      end
      ST_W1:   state_nxt = ST_W2;
      ST_W2:   state_nxt = ST_ANG;
      ST_ANG:  state_nxt = ST_POS;
      ST_POS:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (slot_free) begin
          state_nxt = ST_SCAN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      ch_r       <= '0;
      out_tvalid <= 1'b0;
      for (int k = 0; k < NUM_CHANNELS; k++) begin
        cur_r[k]    <= '0;
        start_r[k]  <= '0;
        tgt_r[k]    <= '0;
        phase_r[k]  <= '0;
        moving_r[k] <= 1'b0;
      end
    end else begin
      state_r <= state_nxt;
      // drop the word once taken, unless the emit step refills the register
      if (out_tvalid && out_tready && state_r != ST_EMIT) begin
        out_tvalid <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          ch_r <= '0;
          if (q_valid && !head.tick) begin
            tgt_r[set_i]    <= head.target;
            start_r[set_i]  <= cur_r[set_i];
            moving_r[set_i] <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (ch_r != CNT_W'(NUM_CHANNELS) && !moving_r[ci]) begin
            ch_r <= ch_r + CNT_W'(1);
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_tvalid        <= 1'b1;
            out_tdata         <= OUT_TDATA_W'({frame_checksum(sid, pos_r), MOVE_TIME,
                                               pos_r, sid});
            out_tlast         <= last_r;
            ch_r              <= ch_r + CNT_W'(1);
            // snap to target and stop once the phase has run out
            if (ph_r >= PHASE_ONE) begin
              cur_r[ci]    <= tgt_r[ci];
              moving_r[ci] <= 1'b0;
              phase_r[ci]  <= '0;
            end else begin
              cur_r[ci]    <= angle_r;
              phase_r[ci]  <= ph_r;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_SCAN: begin
        ph_r   <= ph_sat;
        full_r <= p_full[P_W-1:16] >= (P_W-16)'(WEIGHT_TABLE_DEPTH);
        idx_r  <= TI_W'(p_full[P_W-1:16]);
        frac_r <= p_full[15:0];
        last_r <= !later;
      end
      ST_W1: begin
        acc_r <= full_r ? '0 : 34'(wtab[idx_r]) * (34'(PHASE_ONE) - 34'(frac_r));
      end
      ST_W2: begin
        w_r <= full_r ? PHASE_ONE : PH_W'((acc_r + prod_b) >> 16);
      end
      ST_ANG: begin
        angle_r <= (d < 0) ? start_r[ci] - ANG_W'(mag) : start_r[ci] + ANG_W'(mag);
      end
      ST_POS: begin
        pos_r <= POS_W'(pos_prod >> 20);
      end
      default: ;
    endcase
  end

endmodule

>>> src/multi_axis_cosine_motion_profiler.sv
// channel | handshake              | payload
// in      | in_tvalid/in_tready    | tdata: channel, target_centideg; tuser: command
// out     | out_tvalid/out_tready  | tdata: servo_id, position, move_time, checksum; tlast
// cfg     | cfg_we                 | cfg_wdata: phase_step
// A set-target word is applied in the back end's idle state. A tick walks every
// channel: an idle channel is skipped in the scan step, and a moving one passes
// the scan, two weight products, angle product, divide-by-24 product and emit
// steps, at most one product per step; the walk then returns to idle for a word.
// Reset is synchronous; a stalled output holds the back end in its emit step.
// Top level of the motion profiler; depends on mcp_pkg, mcp_front, mcp_queue, mcp_back.
module multi_axis_cosine_motion_profiler import mcp_pkg::*; #(
  parameter int NUM_CHANNELS       = NUM_CHANNELS_DEF,
  parameter int WEIGHT_TABLE_DEPTH = WEIGHT_TABLE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,   // channel[4:0], target_centideg[20:5], zeros
  input  logic [0:0]             in_tuser,   // command[0]
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,  // servo_id[4:0], position[14:5],
                                             // move_time[22:15], checksum[30:23], zero
  output logic                   out_tlast,
  input  logic                   cfg_we,
  input  logic [PH_W-1:0]        cfg_wdata
);

  logic [PH_W-1:0] phase_step_r;
  logic            push, q_full, pop, q_valid;
  cmd_t            push_cmd, head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_step_r <= PHASE_STEP_RST;
    end else if (cfg_we) begin
      phase_step_r <= cfg_wdata;
    end
  end

  mcp_front #(.NUM_CHANNELS(NUM_CHANNELS)) u_front (
    .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .push, .push_cmd, .q_full
  );

  mcp_queue u_queue (
    .clk, .rst_n, .push, .push_cmd, .full(q_full), .pop, .q_valid, .head
  );

  mcp_back #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .WEIGHT_TABLE_DEPTH(WEIGHT_TABLE_DEPTH)
  ) u_back (
    .clk, .rst_n, .phase_step(phase_step_r), .q_valid, .head, .pop,
    .out_tvalid, .out_tready, .out_tdata, .out_tlast
  );

endmodule

>>> src/mcp_checker.sv
// Port-level checks of the motion profiler's frames, bound to the top level.
// Depends on mcp_pkg and the assertion macro header.
`include "multi_axis_cosine_motion_profiler_assert.svh"
module mcp_checker import mcp_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tlast
);

  `MCP_ASSERT_IMP(a_time_byte, clk, rst_n, out_tvalid, out_tdata[22:15] == MOVE_TIME, "bad time byte")
  `MCP_ASSERT_IMP(a_checksum, clk, rst_n, out_tvalid, out_tdata[30:23] == frame_checksum(out_tdata[4:0], out_tdata[14:5]), "bad checksum")
  `MCP_ASSERT_IMP(a_pos_range, clk, rst_n, out_tvalid, out_tdata[14:5] <= 10'd1000 && out_tdata[4:0] != 5'd0, "frame out of range")
  `MCP_ASSERT_NXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "frame dropped under stall")

endmodule

bind multi_axis_cosine_motion_profiler mcp_checker u_mcp_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tlast
);
